[sv/i2cbc_pkg.sv]
// Shared types, codes and constants of the I2C controller block.
`default_nettype none
package i2cbc_pkg;

   typedef enum logic [2:0] {
      FUNC_READ  = 3'd0,
      FUNC_WRITE = 3'd1,
      FUNC_DONE  = 3'd2,
      FUNC_IRQ   = 3'd3,
      FUNC_TIME  = 3'd4
   } func_type;

   typedef struct packed {
      logic       stop;
      logic       start;
      logic       ack;
      logic       dir;
      logic       irqen;
      logic       busy;
      logic       selected;
      logic [7:0] cur_dev;
   } ctl_type;

   localparam logic [19:0] BUS1_PAGE = 20'h10144;
   localparam logic [19:0] BUS2_PAGE = 20'h10148;
   localparam logic [11:0] REG_DATA  = 12'h000;
   localparam logic [11:0] REG_CTL   = 12'h001;

   localparam logic [6:0] IRQ_BUS0 = 7'h54;
   localparam logic [6:0] IRQ_BUS1 = 7'h55;
   localparam logic [6:0] IRQ_BUS2 = 7'h5C;
   localparam logic [6:0] IRQ_MCU  = 7'h71;

   localparam logic [7:0] DEV_MCU   = 8'h4A;
   localparam logic [7:0] DEV_CAM_A = 8'h78;
   localparam logic [7:0] DEV_CAM_B = 8'h7A;

   localparam logic [7:0] MCU_FW_REG     = 8'h07;
   localparam logic [7:0] MCU_POWER_REG  = 8'h20;
   localparam logic [7:0] MCU_SCHED_REG  = 8'h22;
   localparam logic [7:0] MCU_STREAM_REG = 8'h7F;
   localparam logic [4:0] STREAM_ON      = 5'd18;
   localparam logic [4:0] STREAM_MAX     = 5'd31;

   function automatic logic [7:0] ctl_byte(input ctl_type c);
      ctl_byte = {c.busy, c.irqen, c.dir, c.ack, 2'b00, c.start, c.stop};
   endfunction

   function automatic logic [6:0] bus_irq(input logic [1:0] b);
      case (b)
         2'd0:    bus_irq = IRQ_BUS0;
         2'd1:    bus_irq = IRQ_BUS1;
         default: bus_irq = IRQ_BUS2;
      endcase
   endfunction

   function automatic logic [7:0] mcu_const(input logic [7:0] r);
      case (r)
         8'h00:   mcu_const = 8'hFF;
         8'h01:   mcu_const = 8'hFF;
         8'h0B:   mcu_const = 8'd100;
         8'h0F:   mcu_const = 8'h02;
         8'h61:   mcu_const = 8'h01;
         default: mcu_const = 8'h00;
      endcase
   endfunction

endpackage
`default_nettype wire

[sv/i2cbc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module i2cbc_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

[sv/i2c_bus_controller_with_mcu.sv]
// Pipeline: an accepted beat passes through the P and X registers into the result register.
// Throughput: one beat per cycle unless req_stall is high; the device-table RAM is read one stage ahead
//   of the execute stage, with write-to-read forwarding between the two.
// Reset: synchronous, active high; after reset a clearing pass zeroes the
//   device table, during which req_stall stays high.
`default_nettype none
module i2c_bus_controller_with_mcu #(
   parameter int NUM_BUSES       = 3,
   parameter int DEVICES_PER_BUS = 128,
   parameter int FW_SKIP         = 16384
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [31:0] req_address,
   input  wire logic [7:0]  req_write_data,
   input  wire logic [1:0]  req_event_bus,
   input  wire logic [4:0]  req_mcu_irq_bit,
   input  wire logic [2:0]  req_time_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_irq_valid,
   output logic [6:0]       rsp_irq_number,
   output logic             rsp_transfer_request,
   output logic [1:0]       rsp_transfer_bus,
   output logic [5:0]       rsp_mcu_irq_schedule_mask,
   output logic             rsp_power_off,
   output logic             rsp_reboot
);
   // Device index width and table geometry: one row block per bus.
   localparam int IXW = (DEVICES_PER_BUS > 1) ? $clog2(DEVICES_PER_BUS) : 1;
   localparam int AW  = IXW + 2;
   localparam int RAM_DEPTH = 1 << AW;

   // Constant fold of (dev >> 1) mod DEVICES_PER_BUS.
   logic [IXW-1:0] dix_tab [128];
   for (genvar g = 0; g < 128; g++) begin : g_dix
      assign dix_tab[g] = IXW'(g % DEVICES_PER_BUS);
   end

   // Architectural state.
   logic [7:0]   db_ff   [NUM_BUSES];
   logic [7:0]   db_in   [NUM_BUSES];
   i2cbc_pkg::ctl_type ctl_ff [NUM_BUSES];
   i2cbc_pkg::ctl_type ctl_in [NUM_BUSES];
   logic [7:0]   pend_ff [4];
   logic [7:0]   pend_in [4];
   logic [7:0]   mclk_ff [7];
   logic [7:0]   mclk_in [7];
   logic [4:0]   sp_ff, sp_in;
   logic [14:0]  fw_ff, fw_in;

   // Clearing pass.
   logic          clr_active_ff;
   logic [AW-1:0] clr_cnt_ff;

   // Pipeline: P issues the table read, X executes, rsp holds the result.
   logic        advance;
   logic        accept;
   logic        p_valid_ff;
   logic [2:0]  p_func_ff;
   logic [31:0] p_addr_ff;
   logic [7:0]  p_wd_ff;
   logic [1:0]  p_ev_ff;
   logic [4:0]  p_bit_ff;
   logic [2:0]  p_ti_ff;
   logic        x_valid_ff;
   logic [2:0]  x_func_ff;
   logic [31:0] x_addr_ff;
   logic [7:0]  x_wd_ff;
   logic [1:0]  x_ev_ff;
   logic [4:0]  x_bit_ff;
   logic [2:0]  x_ti_ff;

   // Table port.
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [8:0]    ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [8:0]    ram_rdata;
   logic          byp_ff;
   logic [8:0]    byp_data_ff;
   logic [8:0]    qx;

   // Execute-stage results.
   logic          tw_en;
   logic [8:0]    tw_data;
   logic [AW-1:0] x_taddr;
   logic [7:0]    x_dev;
   logic [7:0]    p_dev;
   logic [1:0]    xid;
   logic [7:0]    mr;
   logic [7:0]    nreg;
   logic          hold;
   logic          is_mcu;
   logic          is_cam;
   i2cbc_pkg::ctl_type xc;
   logic [7:0]    rd;
   logic          irqv;
   logic [6:0]    irqn;
   logic          treq;
   logic [1:0]    tbus;
   logic [5:0]    sched;
   logic          pwr;
   logic          rbt;

   // Result register.
   logic        rsp_valid_ff;
   logic [7:0]  rsp_rd_ff;
   logic        rsp_irqv_ff;
   logic [6:0]  rsp_irqn_ff;
   logic        rsp_treq_ff;
   logic [1:0]  rsp_tbus_ff;
   logic [5:0]  rsp_sched_ff;
   logic        rsp_pwr_ff;
   logic        rsp_rbt_ff;

   // Hold the whole pipe while the result beat waits.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = clr_active_ff || !advance;
   assign accept    = req_valid && !req_stall;

   function automatic logic [1:0] bus_of(input logic [31:0] a);
      logic [1:0] id;
      id = 2'd0;
      if (a[31:12] == i2cbc_pkg::BUS1_PAGE) id = 2'd1;
      if (a[31:12] == i2cbc_pkg::BUS2_PAGE) id = 2'd2;
      if (32'(id) >= NUM_BUSES) id = 2'd0;
      return id;
   endfunction

   // Pick the forwarded table entry when the item ahead in X wrote that same entry.
   assign qx = byp_ff ? byp_data_ff : ram_rdata;
   assign xid = bus_of(x_addr_ff);
   assign xc  = ctl_ff[x_ev_ff];
   assign x_dev = xc.start ? {db_ff[x_ev_ff][7:1], 1'b0} : xc.cur_dev;
   assign x_taddr = {x_ev_ff, dix_tab[x_dev[7:1]]};
   assign mr = qx[7:0];
   assign is_mcu = (x_ev_ff == 2'd1) && (x_dev == i2cbc_pkg::DEV_MCU);
   assign is_cam = ((x_ev_ff == 2'd0) &&
                    ((x_dev == i2cbc_pkg::DEV_CAM_A) || (x_dev == i2cbc_pkg::DEV_CAM_B)))
                   || ((x_ev_ff == 2'd1) && (x_dev == i2cbc_pkg::DEV_CAM_A));

   // Execute one item: short read-modify-write of the small tables.
   always_comb begin
      db_in   = db_ff;
      ctl_in  = ctl_ff;
      pend_in = pend_ff;
      mclk_in = mclk_ff;
      sp_in   = sp_ff;
      fw_in   = fw_ff;
      rd = 8'h00; irqv = 1'b0; irqn = 7'h00; treq = 1'b0; tbus = 2'd0;
      sched = 6'h00; pwr = 1'b0; rbt = 1'b0;
      tw_en = 1'b0; tw_data = qx; hold = 1'b0; nreg = mr + 8'd1;
      if (x_valid_ff) begin
         case (i2cbc_pkg::func_type'(x_func_ff))
            i2cbc_pkg::FUNC_READ: begin
               if (x_addr_ff[11:0] == i2cbc_pkg::REG_DATA) begin
                  rd = db_ff[xid];
               end else if (x_addr_ff[11:0] == i2cbc_pkg::REG_CTL) begin
                  rd = i2cbc_pkg::ctl_byte(ctl_ff[xid]);
               end
            end
            i2cbc_pkg::FUNC_WRITE: begin
               if (x_addr_ff[11:0] == i2cbc_pkg::REG_DATA) begin
                  db_in[xid] = x_wd_ff;
               end else if (x_addr_ff[11:0] == i2cbc_pkg::REG_CTL) begin
                  ctl_in[xid].stop  = x_wd_ff[0];
                  ctl_in[xid].start = x_wd_ff[1];
                  if (x_wd_ff[4]) ctl_in[xid].ack = 1'b0;
                  ctl_in[xid].dir   = x_wd_ff[5];
                  ctl_in[xid].irqen = x_wd_ff[6];
                  if (x_wd_ff[7]) begin
                     ctl_in[xid].ack  = 1'b1;
                     ctl_in[xid].busy = 1'b1;
                     treq = 1'b1;
                     tbus = xid;
                  end
               end
            end
            i2cbc_pkg::FUNC_DONE: begin
               if (32'(x_ev_ff) < NUM_BUSES) begin
                  ctl_in[x_ev_ff].busy = 1'b0;
                  if (xc.start) begin
                     // Select a device; drop its register pointer if newly selected.
                     if (!xc.selected) begin
                        tw_en   = 1'b1;
                        tw_data = {1'b0, mr};
                     end
                     ctl_in[x_ev_ff].selected = 1'b1;
                     ctl_in[x_ev_ff].cur_dev  = x_dev;
                  end else begin
                     tw_en = 1'b1;
                     if (!qx[8]) begin
                        tw_data = {1'b1, db_ff[x_ev_ff]};
                     end else begin
                        if (xc.dir) begin
                           if (is_mcu) begin
                              if (mr[7:2] == 6'b000100) begin
                                 db_in[x_ev_ff] = pend_ff[mr[1:0]];
                                 pend_in[mr[1:0]] = 8'h00;
                              end else if ((mr[7:4] == 4'h3) && (mr[3:0] < 4'd7)) begin
                                 db_in[x_ev_ff] = mclk_ff[mr[2:0]];
                              end else if (mr == i2cbc_pkg::MCU_STREAM_REG) begin
                                 db_in[x_ev_ff] = (sp_ff >= i2cbc_pkg::STREAM_ON) ?
                                                  8'hFF : 8'h00;
                                 if (sp_ff < i2cbc_pkg::STREAM_MAX) sp_in = sp_ff + 5'd1;
                                 hold = 1'b1;
                              end else begin
                                 db_in[x_ev_ff] = i2cbc_pkg::mcu_const(mr);
                              end
                           end else if (is_cam) begin
                              db_in[x_ev_ff] = 8'hFF;
                           end else begin
                              db_in[x_ev_ff] = 8'h00;
                           end
                        end else if (is_mcu) begin
                           if (fw_ff != 15'd0) begin
                              fw_in = fw_ff - 15'd1;
                           end else if (mr == i2cbc_pkg::MCU_FW_REG) begin
                              fw_in = 15'(FW_SKIP);
                           end else if (mr == i2cbc_pkg::MCU_POWER_REG) begin
                              if (db_ff[x_ev_ff][0]) pwr = 1'b1;
                              else if (db_ff[x_ev_ff][2]) rbt = 1'b1;
                           end else if (mr == i2cbc_pkg::MCU_SCHED_REG) begin
                              sched = db_ff[x_ev_ff][5:0];
                           end
                        end
                        if (hold) nreg = mr;
                        tw_data = {1'b1, nreg};
                     end
                     if (xc.stop) begin
                        tw_data[8] = 1'b0;
                        ctl_in[x_ev_ff].selected = 1'b0;
                     end
                  end
                  if (xc.irqen) begin
                     irqv = 1'b1;
                     irqn = i2cbc_pkg::bus_irq(x_ev_ff);
                  end
               end
            end
            i2cbc_pkg::FUNC_IRQ: begin
               pend_in[x_bit_ff[4:3]][x_bit_ff[2:0]] = 1'b1;
               irqv = 1'b1;
               irqn = i2cbc_pkg::IRQ_MCU;
            end
            i2cbc_pkg::FUNC_TIME: begin
               if (x_ti_ff < 3'd7) mclk_in[x_ti_ff] = x_wd_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // Read address for the item in P, seen through X's pending update.
   always_comb begin
      p_dev = 8'h00;
      if (32'(p_ev_ff) < NUM_BUSES) begin
         p_dev = ctl_in[p_ev_ff].start ? {db_in[p_ev_ff][7:1], 1'b0}
                                       : ctl_in[p_ev_ff].cur_dev;
      end
   end
   assign ram_raddr = {p_ev_ff, dix_tab[p_dev[7:1]]};

   // Clearing pass owns the write port right after reset.
   assign ram_we    = clr_active_ff || (tw_en && advance);
   assign ram_waddr = clr_active_ff ? clr_cnt_ff : x_taddr;
   assign ram_wdata = clr_active_ff ? 9'h000 : tw_data;

   i2cbc_ram #(
      .WIDTH (9),
      .DEPTH (RAM_DEPTH)
   ) u_dev_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (advance),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else if (clr_active_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(RAM_DEPTH - 1)) clr_active_ff <= 1'b0;
      end
   end

   // Advance the pipe and commit state.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         x_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_ff       <= 1'b0;
         sp_ff        <= '0;
         fw_ff        <= '0;
         for (int i = 0; i < NUM_BUSES; i++) begin
            db_ff[i]  <= '0;
            ctl_ff[i] <= '0;
         end
         for (int i = 0; i < 4; i++) pend_ff[i] <= '0;
         for (int i = 0; i < 7; i++) mclk_ff[i] <= '0;
      end else if (advance) begin
         p_valid_ff   <= accept;
         x_valid_ff   <= p_valid_ff;
         rsp_valid_ff <= x_valid_ff;
         byp_ff       <= tw_en && (x_taddr == ram_raddr);
         db_ff   <= db_in;
         ctl_ff  <= ctl_in;
         pend_ff <= pend_in;
         mclk_ff <= mclk_in;
         sp_ff   <= sp_in;
         fw_ff   <= fw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_func_ff <= req_func;
         p_addr_ff <= req_address;
         p_wd_ff   <= req_write_data;
         p_ev_ff   <= req_event_bus;
         p_bit_ff  <= req_mcu_irq_bit;
         p_ti_ff   <= req_time_index;
         x_func_ff <= p_func_ff;
         x_addr_ff <= p_addr_ff;
         x_wd_ff   <= p_wd_ff;
         x_ev_ff   <= p_ev_ff;
         x_bit_ff  <= p_bit_ff;
         x_ti_ff   <= p_ti_ff;
         byp_data_ff  <= tw_data;
         rsp_rd_ff    <= rd;
         rsp_irqv_ff  <= irqv;
         rsp_irqn_ff  <= irqn;
         rsp_treq_ff  <= treq;
         rsp_tbus_ff  <= tbus;
         rsp_sched_ff <= sched;
         rsp_pwr_ff   <= pwr;
         rsp_rbt_ff   <= rbt;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_read_data             = rsp_rd_ff;
   assign rsp_irq_valid             = rsp_irqv_ff;
   assign rsp_irq_number            = rsp_irqn_ff;
   assign rsp_transfer_request      = rsp_treq_ff;
   assign rsp_transfer_bus          = rsp_tbus_ff;
   assign rsp_mcu_irq_schedule_mask = rsp_sched_ff;
   assign rsp_power_off             = rsp_pwr_ff;
   assign rsp_reboot                = rsp_rbt_ff;
endmodule
`default_nettype wire

[sv/i2cbc_chk.sv]
// Port-level checker for the I2C controller block, bound to the top level.
`default_nettype none
module i2cbc_chk (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_read_data,
   input wire logic       rsp_irq_valid,
   input wire logic [6:0] rsp_irq_number,
   input wire logic       rsp_transfer_request,
   input wire logic [1:0] rsp_transfer_bus,
   input wire logic       rsp_power_off,
   input wire logic       rsp_reboot
);
   a_clear_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input taken during table clear");

   a_irq_number: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_irq_valid |-> rsp_irq_number == 7'h00)
      else $error("irq number without irq");

   a_power_reboot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_power_off && rsp_reboot))
      else $error("power off and reboot together");

   a_tbus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_transfer_request |-> rsp_transfer_bus == 2'd0)
      else $error("transfer bus without request");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled beat changed");
endmodule

bind i2c_bus_controller_with_mcu i2cbc_chk u_chk (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_read_data        (rsp_read_data),
   .rsp_irq_valid        (rsp_irq_valid),
   .rsp_irq_number       (rsp_irq_number),
   .rsp_transfer_request (rsp_transfer_request),
   .rsp_transfer_bus     (rsp_transfer_bus),
   .rsp_power_off        (rsp_power_off),
   .rsp_reboot           (rsp_reboot)
);
`default_nettype wire
